// ===== src/hsvrgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared constants, codes and stage word types of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	localparam int CHANNEL_FRAC_BITS = 16;
	localparam int HUE_FRAC_BITS     = 6;

	localparam int CH_W    = CHANNEL_FRAC_BITS + 1;
	localparam int HUE_W   = 16;
	localparam int PROD_W  = 2 * CH_W;

	localparam int HUE_SECTOR  = 60 << HUE_FRAC_BITS;
	localparam int HUE_FULL    = 360 << HUE_FRAC_BITS;
	localparam int NUM_SECTORS = 6;
	localparam int SECTOR_BITS = $clog2(HUE_SECTOR);

	// compare width for hue: holds the positive hue field and a full turn
	localparam int HUE_EXT_W = (SECTOR_BITS + 3 > HUE_W - 1) ? SECTOR_BITS + 3 : HUE_W - 1;

	// reciprocal of the sector width, rounded up, exact for every remainder
	localparam int RECIP_SHIFT = 2 * SECTOR_BITS;
	localparam int RECIP_EXP   = CHANNEL_FRAC_BITS + RECIP_SHIFT;
	localparam int RECIP_W     = CHANNEL_FRAC_BITS + SECTOR_BITS + 1;
	localparam int FRAC_PROD_W = SECTOR_BITS + RECIP_W;
	localparam longint unsigned RECIP =
		((64'd1 << RECIP_EXP) + 64'(HUE_SECTOR) - 64'd1) / 64'(HUE_SECTOR);

	localparam logic [CH_W-1:0] CH_ONE = {1'b1, {CHANNEL_FRAC_BITS{1'b0}}};

	typedef logic [CH_W-1:0]              chan_t;
	typedef logic [CHANNEL_FRAC_BITS-1:0] frac_t;
	typedef logic [SECTOR_BITS-1:0]       rem_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_HUE_RANGE = 2'd1,
		ST_SAT_RANGE = 2'd2,
		ST_VAL_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	typedef struct packed {
		status_t status;
		sector_t sector;
		rem_t    rem;
		chan_t   sat;
		chan_t   val;
	} sector_word_t;

	typedef struct packed {
		status_t status;
		sector_t sector;
		chan_t   val;
		chan_t   p;
		chan_t   q;
		chan_t   t;
	} terms_word_t;

endpackage

// ===== src/hsvrgb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb channel interfaces
// Valid/ready channels for HSV pixels in and RGB pixels out.
// ----------------------------------------------------------------------------
interface hsv_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [hsvrgb_pkg::HUE_W-1:0]   hue;
	logic        [hsvrgb_pkg::CH_W-1:0]    saturation;
	logic        [hsvrgb_pkg::CH_W-1:0]    brightness;

	modport source (output valid, hue, saturation, brightness, input ready);
	modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

interface rgb_if;
	logic                              valid;
	logic                              ready;
	logic [hsvrgb_pkg::CH_W-1:0]       red;
	logic [hsvrgb_pkg::CH_W-1:0]       green;
	logic [hsvrgb_pkg::CH_W-1:0]       blue;
	logic [1:0]                        status;

	modport source (output valid, red, green, blue, status, input ready);
	modport sink   (input valid, red, green, blue, status, output ready);
endinterface

// ===== src/hsv_to_rgb_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Fixed point HSV to RGB pixel conversion, five stage pipeline.
// ----------------------------------------------------------------------------
//  channel   dir  fields                             word
//  pix_in    in   hue, saturation, brightness        one HSV pixel
//  pix_out   out  red, green, blue, status           one RGB pixel
//
// one word per clock while pix_out.ready is held; five register stages, a word
// accepted on pix_in is registered by each of them in turn before pix_out
// (checks, fraction, s*f products, q/t products, sector select)
// arst_n clears the stage valid bits only, no payload reset
// each stage loads when empty or when the stage after it moves, so bubbles
// close up and pix_in.ready drops only when every stage holds a word
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
	input  logic  clk,
	input  logic  arst_n,
	hsv_if.sink   pix_in,
	rgb_if.source pix_out
);

	logic                     sec_valid;
	logic                     terms_ready;
	hsvrgb_pkg::sector_word_t sec_word;
	logic                     terms_valid;
	logic                     sel_ready;
	hsvrgb_pkg::terms_word_t  terms_word;

	hsvrgb_sector u_sector (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (pix_in.valid),
		.in_ready   (pix_in.ready),
		.hue        (pix_in.hue),
		.saturation (pix_in.saturation),
		.brightness (pix_in.brightness),
		.out_valid  (sec_valid),
		.out_ready  (terms_ready),
		.out_word   (sec_word)
	);

	hsvrgb_terms u_terms (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sec_valid),
		.in_ready  (terms_ready),
		.in_word   (sec_word),
		.out_valid (terms_valid),
		.out_ready (sel_ready),
		.out_word  (terms_word)
	);

	hsvrgb_select u_select (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (terms_valid),
		.in_ready (sel_ready),
		.in_word  (terms_word),
		.pix_out  (pix_out)
	);

	// error words never carry color
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && pix_out.status != hsvrgb_pkg::ST_OK
			|-> pix_out.red == '0 && pix_out.green == '0 && pix_out.blue == '0)
		else $error("error word with nonzero channel");

	// good words stay within 0..1.0
	a_ok_range: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && pix_out.status == hsvrgb_pkg::ST_OK
			|-> pix_out.red <= hsvrgb_pkg::CH_ONE && pix_out.green <= hsvrgb_pkg::CH_ONE
				&& pix_out.blue <= hsvrgb_pkg::CH_ONE)
		else $error("channel above one");

	// input stalls only with the whole pipe full and the output blocked
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> sec_valid && terms_valid && pix_out.valid && !pix_out.ready)
		else $error("input stalled with a bubble in the pipe");

endmodule

// ===== src/hsvrgb_sector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_sector
// Stage 1: range checks, full-turn wrap, sector index and remainder.
// ----------------------------------------------------------------------------
module hsvrgb_sector (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [hsvrgb_pkg::HUE_W-1:0] hue,
	input  hsvrgb_pkg::chan_t                   saturation,
	input  hsvrgb_pkg::chan_t                   brightness,
	output logic                                out_valid,
	input  logic                                out_ready,
	output hsvrgb_pkg::sector_word_t            out_word
);

	logic                               valid_s1;
	hsvrgb_pkg::sector_word_t           word_s1;
	hsvrgb_pkg::sector_word_t           word_d;
	logic [hsvrgb_pkg::HUE_EXT_W-1:0]   hue_ext;
	logic [hsvrgb_pkg::HUE_EXT_W-1:0]   hue_wrap;
	logic [hsvrgb_pkg::HUE_EXT_W-1:0]   base;

	assign in_ready = !valid_s1 || out_ready;

	always_comb begin
		hue_ext  = hsvrgb_pkg::HUE_EXT_W'(hue[hsvrgb_pkg::HUE_W-2:0]);
		hue_wrap = (hue_ext == hsvrgb_pkg::HUE_EXT_W'(hsvrgb_pkg::HUE_FULL)) ? '0 : hue_ext;

		word_d.sector = hsvrgb_pkg::SEC_RED_YEL;
		base          = '0;
		// thresholds are independent constants, last one passed wins
		for (int k = 1; k < hsvrgb_pkg::NUM_SECTORS; k++) begin
			if (hue_wrap >= hsvrgb_pkg::HUE_EXT_W'(k * hsvrgb_pkg::HUE_SECTOR)) begin
				word_d.sector = hsvrgb_pkg::sector_t'(3'(k));
				base          = hsvrgb_pkg::HUE_EXT_W'(k * hsvrgb_pkg::HUE_SECTOR);
			end
		end
		word_d.rem = hsvrgb_pkg::SECTOR_BITS'(hue_wrap - base);
		word_d.sat = saturation;
		word_d.val = brightness;

		if (hue[hsvrgb_pkg::HUE_W-1]
				|| hue_ext > hsvrgb_pkg::HUE_EXT_W'(hsvrgb_pkg::HUE_FULL)) begin
			word_d.status = hsvrgb_pkg::ST_HUE_RANGE;
		end else if (saturation > hsvrgb_pkg::CH_ONE) begin
			word_d.status = hsvrgb_pkg::ST_SAT_RANGE;
		end else if (brightness > hsvrgb_pkg::CH_ONE) begin
			word_d.status = hsvrgb_pkg::ST_VAL_RANGE;
		end else begin
			word_d.status = hsvrgb_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= word_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_word  = word_s1;

endmodule

// ===== src/hsvrgb_terms.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_terms
// Stages 2 to 4: sector fraction, then the p, q and t products.
// ----------------------------------------------------------------------------
module hsvrgb_terms (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  hsvrgb_pkg::sector_word_t in_word,
	output logic                     out_valid,
	input  logic                     out_ready,
	output hsvrgb_pkg::terms_word_t  out_word
);

	logic                                  valid_s2;
	logic                                  valid_s3;
	logic                                  valid_s4;
	logic                                  en_s2;
	logic                                  en_s3;
	logic                                  en_s4;

	hsvrgb_pkg::status_t                   status_s2;
	hsvrgb_pkg::status_t                   status_s3;
	hsvrgb_pkg::sector_t                   sector_s2;
	hsvrgb_pkg::sector_t                   sector_s3;
	hsvrgb_pkg::chan_t                     sat_s2;
	hsvrgb_pkg::chan_t                     val_s2;
	hsvrgb_pkg::chan_t                     val_s3;
	hsvrgb_pkg::frac_t                     frac_s2;
	hsvrgb_pkg::chan_t                     p_s2;
	hsvrgb_pkg::chan_t                     p_s3;
	hsvrgb_pkg::chan_t                     sf_s3;
	hsvrgb_pkg::chan_t                     sfn_s3;
	hsvrgb_pkg::terms_word_t               word_s4;

	logic [hsvrgb_pkg::FRAC_PROD_W-1:0]    frac_prod;
	hsvrgb_pkg::chan_t                     one_minus_s;
	logic [hsvrgb_pkg::PROD_W-1:0]         p_prod;
	hsvrgb_pkg::chan_t                     one_minus_f;
	logic [hsvrgb_pkg::PROD_W-1:0]         sf_prod;
	logic [hsvrgb_pkg::PROD_W-1:0]         sfn_prod;
	hsvrgb_pkg::chan_t                     one_minus_sf;
	hsvrgb_pkg::chan_t                     one_minus_sfn;
	logic [hsvrgb_pkg::PROD_W-1:0]         q_prod;
	logic [hsvrgb_pkg::PROD_W-1:0]         t_prod;

	// a stage loads when empty or when the next one moves on
	assign en_s4    = !valid_s4 || out_ready;
	assign en_s3    = !valid_s3 || en_s4;
	assign en_s2    = !valid_s2 || en_s3;
	assign in_ready = en_s2;

	// stage 2: f = rem * 2^CF / sector by reciprocal, p = v * (1 - s)
	always_comb begin
		frac_prod   = hsvrgb_pkg::FRAC_PROD_W'(in_word.rem)
			* hsvrgb_pkg::FRAC_PROD_W'(hsvrgb_pkg::RECIP);
		one_minus_s = hsvrgb_pkg::CH_ONE - in_word.sat;
		p_prod      = hsvrgb_pkg::PROD_W'(in_word.val) * hsvrgb_pkg::PROD_W'(one_minus_s);
	end

	// stage 3: s * f and s * (1 - f)
	always_comb begin
		one_minus_f = hsvrgb_pkg::CH_ONE - hsvrgb_pkg::CH_W'(frac_s2);
		sf_prod     = hsvrgb_pkg::PROD_W'(sat_s2) * hsvrgb_pkg::PROD_W'(frac_s2);
		sfn_prod    = hsvrgb_pkg::PROD_W'(sat_s2) * hsvrgb_pkg::PROD_W'(one_minus_f);
	end

	// stage 4: q and t
	always_comb begin
		one_minus_sf  = hsvrgb_pkg::CH_ONE - sf_s3;
		one_minus_sfn = hsvrgb_pkg::CH_ONE - sfn_s3;
		q_prod        = hsvrgb_pkg::PROD_W'(val_s3) * hsvrgb_pkg::PROD_W'(one_minus_sf);
		t_prod        = hsvrgb_pkg::PROD_W'(val_s3) * hsvrgb_pkg::PROD_W'(one_minus_sfn);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s2) begin
				valid_s2 <= in_valid;
			end
			if (en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && in_valid) begin
			status_s2 <= in_word.status;
			sector_s2 <= in_word.sector;
			sat_s2    <= in_word.sat;
			val_s2    <= in_word.val;
			frac_s2   <= frac_prod[hsvrgb_pkg::RECIP_SHIFT +: hsvrgb_pkg::CHANNEL_FRAC_BITS];
			p_s2      <= p_prod[hsvrgb_pkg::CHANNEL_FRAC_BITS +: hsvrgb_pkg::CH_W];
		end
		if (en_s3 && valid_s2) begin
			status_s3 <= status_s2;
			sector_s3 <= sector_s2;
			val_s3    <= val_s2;
			p_s3      <= p_s2;
			sf_s3     <= sf_prod[hsvrgb_pkg::CHANNEL_FRAC_BITS +: hsvrgb_pkg::CH_W];
			sfn_s3    <= sfn_prod[hsvrgb_pkg::CHANNEL_FRAC_BITS +: hsvrgb_pkg::CH_W];
		end
		if (en_s4 && valid_s3) begin
			word_s4.status <= status_s3;
			word_s4.sector <= sector_s3;
			word_s4.val    <= val_s3;
			word_s4.p      <= p_s3;
			word_s4.q      <= q_prod[hsvrgb_pkg::CHANNEL_FRAC_BITS +: hsvrgb_pkg::CH_W];
			word_s4.t      <= t_prod[hsvrgb_pkg::CHANNEL_FRAC_BITS +: hsvrgb_pkg::CH_W];
		end
	end

	assign out_valid = valid_s4;
	assign out_word  = word_s4;

endmodule

// ===== src/hsvrgb_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvrgb_select
// Stage 5: routes v, p, q, t to the channels by sector into the output register.
// ----------------------------------------------------------------------------
module hsvrgb_select (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  hsvrgb_pkg::terms_word_t in_word,
	rgb_if.source                   pix_out
);

	logic                valid_s5;
	hsvrgb_pkg::chan_t   red_s5;
	hsvrgb_pkg::chan_t   green_s5;
	hsvrgb_pkg::chan_t   blue_s5;
	hsvrgb_pkg::status_t status_s5;
	hsvrgb_pkg::chan_t   red_d;
	hsvrgb_pkg::chan_t   green_d;
	hsvrgb_pkg::chan_t   blue_d;

	assign in_ready = !valid_s5 || pix_out.ready;

	always_comb begin
		case (in_word.sector)
			hsvrgb_pkg::SEC_RED_YEL: begin
				red_d = in_word.val; green_d = in_word.t;   blue_d = in_word.p;
			end
			hsvrgb_pkg::SEC_YEL_GRN: begin
				red_d = in_word.q;   green_d = in_word.val; blue_d = in_word.p;
			end
			hsvrgb_pkg::SEC_GRN_CYN: begin
				red_d = in_word.p;   green_d = in_word.val; blue_d = in_word.t;
			end
			hsvrgb_pkg::SEC_CYN_BLU: begin
				red_d = in_word.p;   green_d = in_word.q;   blue_d = in_word.val;
			end
			hsvrgb_pkg::SEC_BLU_MAG: begin
				red_d = in_word.t;   green_d = in_word.p;   blue_d = in_word.val;
			end
			default: begin
				red_d = in_word.val; green_d = in_word.p;   blue_d = in_word.q;
			end
		endcase
		// out of range words carry zero channels
		if (in_word.status != hsvrgb_pkg::ST_OK) begin
			red_d   = '0;
			green_d = '0;
			blue_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (in_ready) begin
			valid_s5 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			red_s5    <= red_d;
			green_s5  <= green_d;
			blue_s5   <= blue_d;
			status_s5 <= in_word.status;
		end
	end

	assign pix_out.valid  = valid_s5;
	assign pix_out.red    = red_s5;
	assign pix_out.green  = green_s5;
	assign pix_out.blue   = blue_s5;
	assign pix_out.status = status_s5;

endmodule
